// ----- design/ifa_pkg.sv -----
// Shared constants, codes and types for the interval first-fit allocator.
package ifa_pkg;

    localparam int MEMORY_LIMIT = 65536;
    localparam int MAX_REGIONS  = 32;
    localparam int IDX_W        = $clog2(MAX_REGIONS);
    localparam int CNT_W        = $clog2(MAX_REGIONS + 1);
    localparam int ADDR_W       = 17;
    localparam int OFF_W        = 16;
    localparam int DIV_STEPS    = ADDR_W;
    localparam int DCNT_W       = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_RESERVE = 2'd1,
        OP_ALLOC   = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CONFLICT = 2'd1,
        ST_NOSPACE  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_ROT  = 2'd1,
        CELL_INS  = 2'd2
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [ADDR_W-1:0]  key;
        logic [ADDR_W-1:0]  ins_end;
    } cell_ctl_t;

endpackage

// ----- design/ifa_if.sv -----
// Request, response and configuration channel interfaces.
interface ifa_req_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic [ifa_pkg::OFF_W-1:0]     region_offset;
    logic [ifa_pkg::ADDR_W-1:0]    region_size;
    logic [ifa_pkg::ADDR_W-1:0]    alignment;

    modport source (output valid, op, region_offset, region_size, alignment, input ready);
    modport sink   (input valid, op, region_offset, region_size, alignment, output ready);
endinterface

interface ifa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    status;
    logic [ifa_pkg::ADDR_W-1:0]    region_begin;
    logic [ifa_pkg::ADDR_W-1:0]    region_end;
    logic [ifa_pkg::ADDR_W-1:0]    allocated_bytes;

    modport source (output valid, status, region_begin, region_end, allocated_bytes,
                    input ready);
    modport sink   (input valid, status, region_begin, region_end, allocated_bytes,
                    output ready);
endinterface

interface ifa_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [ifa_pkg::ADDR_W-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- design/ifa_cell.sv -----
// One table slot: holds a region, compares it to the key, shifts or rotates.
module ifa_cell (
    input  logic                           clk,
    input  ifa_pkg::cell_ctl_t             ctl,
    input  logic                           valid,
    input  logic                           prv_lt,
    input  logic [ifa_pkg::ADDR_W-1:0]     left_start,
    input  logic [ifa_pkg::ADDR_W-1:0]     left_end,
    input  logic [ifa_pkg::ADDR_W-1:0]     right_start,
    input  logic [ifa_pkg::ADDR_W-1:0]     right_end,
    output logic [ifa_pkg::ADDR_W-1:0]     start,
    output logic [ifa_pkg::ADDR_W-1:0]     stop,
    output logic                           lt,
    output logic                           eq
);

    logic [ifa_pkg::ADDR_W-1:0] start_reg, start_next;
    logic [ifa_pkg::ADDR_W-1:0] end_reg, end_next;

    assign lt    = valid && (start_reg < ctl.key);
    assign eq    = valid && (start_reg == ctl.key);
    assign start = start_reg;
    assign stop  = end_reg;

    always_comb
    begin
        start_next = start_reg;
        end_next   = end_reg;
        case (ctl.cmd)
            ifa_pkg::CELL_ROT:
            begin
                start_next = right_start;
                end_next   = right_end;
            end
            ifa_pkg::CELL_INS:
            begin
                // slots below the insert point keep, the insert point loads, the rest shift up
                if (!lt)
                begin
                    if (prv_lt)
                    begin
                        start_next = ctl.key;
                        end_next   = ctl.ins_end;
                    end
                    else
                    begin
                        start_next = left_start;
                        end_next   = left_end;
                    end
                end
            end
            default:
            begin
                start_next = start_reg;
                end_next   = end_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
    end

endmodule

// ----- design/ifa_div.sv -----
// Restoring remainder unit, one quotient bit per cycle.
module ifa_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [ifa_pkg::ADDR_W-1:0]     dividend,
    input  logic [ifa_pkg::ADDR_W-1:0]     divisor,
    output logic                           done,
    output logic [ifa_pkg::ADDR_W-1:0]     rem
);

    logic [ifa_pkg::ADDR_W-1:0]   rem_reg;
    logic [ifa_pkg::ADDR_W-1:0]   dvd_reg;
    logic [ifa_pkg::ADDR_W-1:0]   dsr_reg;
    logic [ifa_pkg::DCNT_W-1:0]   cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [ifa_pkg::ADDR_W:0]     trial;
    logic [ifa_pkg::ADDR_W:0]     diff;

    assign trial = {rem_reg, dvd_reg[ifa_pkg::ADDR_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign done  = done_reg;
    assign rem   = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ifa_pkg::DCNT_W'(ifa_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[ifa_pkg::ADDR_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_reg <= diff[ifa_pkg::ADDR_W-1:0];
            else
                rem_reg <= trial[ifa_pkg::ADDR_W-1:0];
        end
    end

endmodule

// ----- design/interval_first_fit_allocator_unit.sv -----
// Interval first-fit allocator: region table as a ring of cells plus sequencer.
// Allocate: the table ring turns once around its 32 cells, and each region passed before
// a fit holds the ring while the divider forms the remainder.
// One request in flight at a time; the next is taken once the result is registered.
// Reset empties the table, zeroes the byte total and sets base_reg to 0.
module interval_first_fit_allocator_unit (
    input  logic        clk,
    input  logic        rst_n,
    ifa_req_if.sink     req,
    ifa_rsp_if.source   rsp,
    ifa_cfg_if.sink     cfg
);

    localparam int AW = ifa_pkg::ADDR_W;
    localparam int N  = ifa_pkg::MAX_REGIONS;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_WALK  = 5'b00010,
        S_DIV   = 5'b00100,
        S_PLACE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t                         state_reg, state_next;
    logic [AW-1:0]                  base_reg;
    logic [ifa_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [AW-1:0]                  total_reg, total_next;
    ifa_pkg::op_t                   op_reg;
    logic [AW-1:0]                  key_reg;
    logic [AW:0]                    kend_reg;
    logic [AW-1:0]                  size_reg;
    logic [AW-1:0]                  align_reg;
    logic [AW:0]                    start_reg, start_next;
    logic                           found_reg, found_next;
    logic [ifa_pkg::IDX_W-1:0]      r_reg, r_next;
    ifa_pkg::status_t               res_status_reg, res_status_next;
    logic [AW-1:0]                  res_begin_reg, res_begin_next;
    logic [AW-1:0]                  res_end_reg, res_end_next;
    logic                           out_valid_reg;
    logic [1:0]                     out_status_reg;
    logic [AW-1:0]                  out_begin_reg;
    logic [AW-1:0]                  out_end_reg;
    logic [AW-1:0]                  out_bytes_reg;

    ifa_pkg::cell_ctl_t             ctl;
    ifa_pkg::cell_cmd_t             cell_cmd;
    logic [N-1:0]                   cvalid, clt, ceq, cprv;
    logic [AW-1:0]                  cstart [N];
    logic [AW-1:0]                  cend   [N];
    logic                           div_start, div_done;
    logic [AW-1:0]                  div_rem;
    logic [AW+1:0]                  fit_end;
    logic [AW:0]                    next_addr;
    logic                           conflict, held, full, req_acc;

    assign req_acc   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign full      = (count_reg >= ifa_pkg::CNT_W'(N));

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.region_begin    = out_begin_reg;
    assign rsp.region_end      = out_end_reg;
    assign rsp.allocated_bytes = out_bytes_reg;

    assign fit_end   = {1'b0, start_reg} + {2'b00, size_reg};
    // round the region end up to the alignment, never below it
    assign next_addr = (div_rem == '0) ? {1'b0, cend[0]}
                                       : ({1'b0, cend[0]} + {1'b0, align_reg} - {1'b0, div_rem});

    assign ctl.cmd     = cell_cmd;
    assign ctl.key     = (op_reg == ifa_pkg::OP_ALLOC) ? start_reg[AW-1:0] : key_reg;
    assign ctl.ins_end = (op_reg == ifa_pkg::OP_ALLOC) ? fit_end[AW-1:0] : kend_reg[AW-1:0];

    for (genvar g = 0; g < N; g++)
    begin : g_cell
        localparam int L = (g == 0) ? 0 : g - 1;
        localparam int R = (g + 1) % N;
        assign cvalid[g] = (ifa_pkg::CNT_W'(g) < count_reg);
        assign cprv[g]   = (g == 0) ? 1'b1 : clt[L];
        ifa_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .valid       (cvalid[g]),
            .prv_lt      (cprv[g]),
            .left_start  (cstart[L]),
            .left_end    (cend[L]),
            .right_start (cstart[R]),
            .right_end   (cend[R]),
            .start       (cstart[g]),
            .stop        (cend[g]),
            .lt          (clt[g]),
            .eq          (ceq[g])
        );
    end

    ifa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (cend[0]),
        .divisor  (align_reg),
        .done     (div_done),
        .rem      (div_rem)
    );

    // reserve conflict: the slot at the insert point or the one just below it
    always_comb
    begin
        logic nxt_lt;
        conflict = 1'b0;
        for (int k = 0; k < N; k++)
        begin
            nxt_lt = (k == N - 1) ? 1'b0 : clt[(k + 1) % N];
            if (!clt[k] && cprv[k] && cvalid[k] &&
                (({1'b0, cstart[k]} < kend_reg) || (cstart[k] == key_reg)))
                conflict = 1'b1;
            if (clt[k] && !nxt_lt && (cend[k] > key_reg))
                conflict = 1'b1;
        end
    end

    assign held = |ceq;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        start_next      = start_reg;
        found_next      = found_reg;
        r_next          = r_reg;
        res_status_next = res_status_reg;
        res_begin_next  = res_begin_reg;
        res_end_next    = res_end_reg;
        cell_cmd        = ifa_pkg::CELL_HOLD;
        div_start       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    res_status_next = ifa_pkg::ST_OK;
                    res_begin_next  = '0;
                    res_end_next    = '0;
                    start_next      = {1'b0, base_reg};
                    found_next      = 1'b0;
                    r_next          = '0;
                    state_next      = S_DONE;
                    case (ifa_pkg::op_t'(req.op))
                        ifa_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            total_next = '0;
                        end
                        ifa_pkg::OP_RESERVE:
                            state_next = S_PLACE;
                        ifa_pkg::OP_ALLOC:
                        begin
                            if (full)
                                res_status_next = ifa_pkg::ST_FULL;
                            else
                                state_next = S_WALK;
                        end
                        default:
                            state_next = S_DONE;
                    endcase
                end
            end
            S_WALK:
            begin
                if ((ifa_pkg::CNT_W'(r_reg) < count_reg) && !found_reg &&
                    !(fit_end <= {2'b00, cstart[0]}))
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    if ((ifa_pkg::CNT_W'(r_reg) < count_reg) && !found_reg)
                        found_next = 1'b1;
                    cell_cmd = ifa_pkg::CELL_ROT;
                    r_next   = r_reg + 1'b1;
                    if (r_reg == ifa_pkg::IDX_W'(N - 1))
                        state_next = S_PLACE;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (next_addr > start_reg)
                        start_next = next_addr;
                    cell_cmd = ifa_pkg::CELL_ROT;
                    r_next   = r_reg + 1'b1;
                    if (r_reg == ifa_pkg::IDX_W'(N - 1))
                        state_next = S_PLACE;
                    else
                        state_next = S_WALK;
                end
            end
            S_PLACE:
            begin
                state_next = S_DONE;
                if (op_reg == ifa_pkg::OP_ALLOC)
                begin
                    if (found_reg || (fit_end <= (AW + 2)'(ifa_pkg::MEMORY_LIMIT)))
                    begin
                        res_begin_next = start_reg[AW-1:0];
                        res_end_next   = fit_end[AW-1:0];
                        if (!held)
                        begin
                            cell_cmd   = ifa_pkg::CELL_INS;
                            count_next = count_reg + 1'b1;
                            total_next = total_reg + size_reg;
                        end
                    end
                    else
                        res_status_next = ifa_pkg::ST_NOSPACE;
                end
                else
                begin
                    if (kend_reg > (AW + 1)'(ifa_pkg::MEMORY_LIMIT))
                        res_status_next = ifa_pkg::ST_NOSPACE;
                    else if (conflict)
                        res_status_next = ifa_pkg::ST_CONFLICT;
                    else if (full)
                        res_status_next = ifa_pkg::ST_FULL;
                    else
                    begin
                        res_begin_next = key_reg;
                        res_end_next   = kend_reg[AW-1:0];
                        cell_cmd       = ifa_pkg::CELL_INS;
                        count_next     = count_reg + 1'b1;
                        total_next     = total_reg + size_reg;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            base_reg      <= '0;
            r_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            r_reg     <= r_next;
            found_reg <= found_next;
            if (cfg.valid && cfg.ready)
                base_reg <= cfg.data;
            if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        res_status_reg <= res_status_next;
        res_begin_reg  <= res_begin_next;
        res_end_reg    <= res_end_next;
        if (req_acc)
        begin
            op_reg    <= ifa_pkg::op_t'(req.op);
            key_reg   <= {1'b0, req.region_offset};
            kend_reg  <= {2'b00, req.region_offset} + {1'b0, req.region_size};
            size_reg  <= req.region_size;
            align_reg <= (req.alignment == '0) ? AW'(1) : req.alignment;
        end
        if (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
        begin
            out_status_reg <= res_status_reg;
            out_begin_reg  <= res_begin_reg;
            out_end_reg    <= res_end_reg;
            out_bytes_reg  <= total_reg;
        end
    end

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ifa_pkg::CNT_W'(N))
        else $error("region count above table size");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> r_reg == '0)
        else $error("cell ring not back in place when idle");

    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> total_reg == '0)
        else $error("bytes held with an empty table");

    a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> state_reg != S_IDLE)
        else $error("request taken but sequencer stayed idle");

endmodule
